### hdl/pfe_pkg.sv
// ----------------------------------------------------------------------------
// pfe_pkg
// shared types, constants and lookup functions of the playfair encryptor
// ----------------------------------------------------------------------------
package pfe_pkg;

	localparam int SIDE            = 5;
	localparam int CODE_W          = 5;
	localparam int ROW_W           = SIDE * CODE_W;
	localparam int CFG_IDX_W       = 3;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [CODE_W-1:0] LETTER_X = 5'd23;
	localparam logic [CODE_W-1:0] LETTER_J = 5'd9;
	localparam logic [CODE_W-1:0] LETTER_I = 5'd8;

	localparam logic [7:0] ASCII_UPPER_A = 8'h41;
	localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
	localparam logic [7:0] ASCII_LOWER_A = 8'h61;
	localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;

	typedef logic [CODE_W-1:0] code_t;
	typedef logic [2:0]        pos_t;
	typedef logic [ROW_W-1:0]  row_t;
	typedef row_t [SIDE-1:0]   square_t;

	typedef struct packed {
		code_t a;
		code_t b;
	} pair_t;

	// one queue entry: the pairs caused by one accepted byte
	typedef struct packed {
		pair_t first;
		pair_t second;
		logic  two;
		logic  done;
	} entry_t;

	typedef struct packed {
		logic found;
		pos_t row;
		pos_t col;
	} loc_t;

	function automatic code_t cell_at(square_t sq, pos_t r, pos_t c);
		row_t  row;
		code_t letter;
		case (r)
			3'd0:    row = sq[0];
			3'd1:    row = sq[1];
			3'd2:    row = sq[2];
			3'd3:    row = sq[3];
			3'd4:    row = sq[4];
			default: row = sq[0];
		endcase
		case (c)
			3'd0:    letter = row[4:0];
			3'd1:    letter = row[9:5];
			3'd2:    letter = row[14:10];
			3'd3:    letter = row[19:15];
			3'd4:    letter = row[24:20];
			default: letter = row[4:0];
		endcase
		return letter;
	endfunction

	function automatic pos_t next_pos(pos_t p);
		return (p == pos_t'(SIDE - 1)) ? 3'd0 : p + 3'd1;
	endfunction

	// first match in row-major order wins, J is looked up as I
	function automatic loc_t locate(square_t sq, code_t code);
		code_t key;
		loc_t  loc;
		key = (code == LETTER_J) ? LETTER_I : code;
		loc = '0;
		for (int i = SIDE * SIDE - 1; i >= 0; i--) begin
			if (sq[i / SIDE][(i % SIDE) * CODE_W +: CODE_W] == key) begin
				loc.found = 1'b1;
				loc.row   = pos_t'(i / SIDE);
				loc.col   = pos_t'(i % SIDE);
			end
		end
		return loc;
	endfunction

endpackage

### hdl/pfe_in_if.sv
// ----------------------------------------------------------------------------
// pfe_in_if
// plaintext byte channel
// ----------------------------------------------------------------------------
interface pfe_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       message_end;

	modport source (output valid, output char_in, output message_end, input ready);
	modport sink   (input valid, input char_in, input message_end, output ready);
endinterface

### hdl/pfe_out_if.sv
// ----------------------------------------------------------------------------
// pfe_out_if
// cipher letter channel
// ----------------------------------------------------------------------------
interface pfe_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] cipher_char;
	logic       run_last;
	logic       message_done;
	logic       not_in_square;

	modport source (output valid, output cipher_char, output run_last,
		output message_done, output not_in_square, input ready);
	modport sink   (input valid, input cipher_char, input run_last,
		input message_done, input not_in_square, output ready);
endinterface

### hdl/pfe_front.sv
// ----------------------------------------------------------------------------
// pfe_front
// accepts bytes, filters letters and forms the digraphs
// ----------------------------------------------------------------------------
module pfe_front (
	input  logic           clk,
	input  logic           arst_n,
	pfe_in_if.sink         in_stream,
	input  logic           room,
	output logic           push,
	output pfe_pkg::entry_t push_entry
);
	import pfe_pkg::*;

	code_t  pend_q;
	logic   pend_valid_q;
	code_t  nxt_letter;
	logic   nxt_valid;
	logic   is_upper, is_lower, is_letter, has_pair, accept;
	code_t  code;
	logic [7:0] diff;
	entry_t ent;

	assign in_stream.ready = room;
	assign accept = in_stream.valid && room;

	always_comb begin
		is_upper  = (in_stream.char_in >= ASCII_UPPER_A) && (in_stream.char_in <= ASCII_UPPER_Z);
		is_lower  = (in_stream.char_in >= ASCII_LOWER_A) && (in_stream.char_in <= ASCII_LOWER_Z);
		is_letter = is_upper || is_lower;
		diff      = in_stream.char_in - (is_upper ? ASCII_UPPER_A : ASCII_LOWER_A);
		code      = diff[CODE_W-1:0];
	end

	always_comb begin
		nxt_letter = pend_q;
		nxt_valid  = pend_valid_q;
		ent        = '0;
		has_pair   = 1'b0;
		if (is_letter) begin
			if (!pend_valid_q) begin
				nxt_letter = code;
				nxt_valid  = 1'b1;
			end else if (pend_q == code) begin
				// repeat: filler goes in, repeated letter stays pending
				ent.first  = '{a: pend_q, b: LETTER_X};
				has_pair   = 1'b1;
				nxt_letter = code;
			end else begin
				ent.first  = '{a: pend_q, b: code};
				has_pair   = 1'b1;
				nxt_letter = '0;
				nxt_valid  = 1'b0;
			end
		end
		if (in_stream.message_end) begin
			if (nxt_valid) begin
				if (has_pair) begin
					ent.second = '{a: nxt_letter, b: LETTER_X};
					ent.two    = 1'b1;
				end else begin
					ent.first  = '{a: nxt_letter, b: LETTER_X};
				end
				has_pair = 1'b1;
			end
			nxt_letter = '0;
			nxt_valid  = 1'b0;
		end
		ent.done = in_stream.message_end;
	end

	assign push       = accept && has_pair;
	assign push_entry = ent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q       <= '0;
			pend_valid_q <= 1'b0;
		end else if (accept) begin
			pend_q       <= nxt_letter;
			pend_valid_q <= nxt_valid;
		end
	end

endmodule

### hdl/pfe_queue.sv
// ----------------------------------------------------------------------------
// pfe_queue
// short queue of digraph entries between front and back
// ----------------------------------------------------------------------------
module pfe_queue #(
	parameter int unsigned DEPTH = pfe_pkg::QUEUE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  pfe_pkg::entry_t push_entry,
	output logic            room,
	input  logic            pop,
	output logic            head_valid,
	output pfe_pkg::entry_t head
);
	import pfe_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	entry_t             store_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push, do_pop;

	function automatic logic [PTR_W-1:0] bump(logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign room       = (count_q != CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = store_q[rd_ptr_q];
	assign do_push    = push && room;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= bump(wr_ptr_q);
			if (do_pop)  rd_ptr_q <= bump(rd_ptr_q);
			if (do_push && !do_pop)      count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) store_q[wr_ptr_q] <= push_entry;
	end

endmodule

### hdl/pfe_back.sv
// ----------------------------------------------------------------------------
// pfe_back
// locates each digraph in the key square and sends two cipher letters
// ----------------------------------------------------------------------------
module pfe_back (
	input  logic             clk,
	input  logic             arst_n,
	input  pfe_pkg::square_t square,
	input  logic             head_valid,
	input  pfe_pkg::entry_t  head,
	output logic             pop,
	pfe_out_if.source        out_stream
);
	import pfe_pkg::*;

	logic  sel_q;
	logic  valid_s1, idx_s1, last_s1, done_s1;
	code_t a_s1, b_s1;
	loc_t  la_s1, lb_s1;

	logic       out_valid_q;
	logic [7:0] out_char_q;
	logic       out_run_last_q, out_done_q, out_miss_q;

	logic  out_load, s1_free, take, pair_is_last, miss;
	pair_t cur_pair;
	code_t e1, e2, e_sel;

	assign out_load     = !out_valid_q || out_stream.ready;
	assign s1_free      = !valid_s1 || (out_load && idx_s1);
	assign cur_pair     = sel_q ? head.second : head.first;
	assign pair_is_last = !head.two || sel_q;
	assign take         = head_valid && s1_free;
	assign pop          = take && pair_is_last;

	// digraph rules
	always_comb begin
		miss = !(la_s1.found && lb_s1.found);
		if (miss) begin
			e1 = a_s1;
			e2 = b_s1;
		end else if (la_s1.row == lb_s1.row) begin
			e1 = cell_at(square, la_s1.row, next_pos(la_s1.col));
			e2 = cell_at(square, lb_s1.row, next_pos(lb_s1.col));
		end else if (la_s1.col == lb_s1.col) begin
			e1 = cell_at(square, next_pos(la_s1.row), la_s1.col);
			e2 = cell_at(square, next_pos(lb_s1.row), lb_s1.col);
		end else begin
			e1 = cell_at(square, la_s1.row, lb_s1.col);
			e2 = cell_at(square, lb_s1.row, la_s1.col);
		end
		e_sel = idx_s1 ? e2 : e1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q       <= 1'b0;
			valid_s1    <= 1'b0;
			idx_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) out_valid_q <= valid_s1;
			// a new pair taken in the same cycle refills the stage
			if (out_load && valid_s1 && !take) begin
				if (!idx_s1) idx_s1 <= 1'b1;
				else         valid_s1 <= 1'b0;
			end
			if (take) begin
				sel_q    <= !pair_is_last;
				valid_s1 <= 1'b1;
				idx_s1   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			a_s1    <= cur_pair.a;
			b_s1    <= cur_pair.b;
			la_s1   <= locate(square, cur_pair.a);
			lb_s1   <= locate(square, cur_pair.b);
			last_s1 <= pair_is_last;
			done_s1 <= head.done && pair_is_last;
		end
		if (out_load && valid_s1) begin
			out_char_q     <= ASCII_UPPER_A + {3'b000, e_sel};
			out_run_last_q <= idx_s1 && last_s1;
			out_done_q     <= idx_s1 && done_s1;
			out_miss_q     <= miss;
		end
	end

	assign out_stream.valid         = out_valid_q;
	assign out_stream.cipher_char   = out_char_q;
	assign out_stream.run_last      = out_run_last_q;
	assign out_stream.message_done  = out_done_q;
	assign out_stream.not_in_square = out_miss_q;

endmodule

### hdl/playfair_digraph_encryptor_core.sv
// ----------------------------------------------------------------------------
// playfair_digraph_encryptor_core
// streaming playfair encryptor with a configurable 5x5 key square
// ----------------------------------------------------------------------------
// Takes one ASCII byte per transfer on in_stream; letters are folded to
// upper case and paired, everything else is dropped. A doubled letter gets
// an X filler and a lone letter at message end is padded with X. Each pair
// leaves out_stream as two cipher letters, one transfer per cycle while
// out_stream.ready holds; a byte causes 0, 2 or 4 letters. A byte is taken
// in every cycle while the digraph queue (QUEUE_DEPTH entries) has room, so
// new bytes enter before the letters of earlier ones have left. The output
// letter register sets the ceiling of one letter per cycle. A byte's letters
// pass the queue, the lookup stage and the output register in turn. Square
// rows must be written by the user via wr_en / wr_index / wr_data only while
// the block is idle, which it does not enforce; unknown indices are ignored.
module playfair_digraph_encryptor_core #(
	parameter int unsigned QUEUE_DEPTH = pfe_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	pfe_in_if.sink                          in_stream,
	pfe_out_if.source                       out_stream,
	input  logic                            wr_en,
	input  logic [pfe_pkg::CFG_IDX_W-1:0]   wr_index,
	input  logic [pfe_pkg::ROW_W-1:0]       wr_data
);
	import pfe_pkg::*;

	// key square rows, column 0 in the low bits
	square_t square_q;

	// front to queue
	logic   push, room;
	entry_t push_entry;

	// queue to back
	logic   pop, head_valid;
	entry_t head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			square_q <= '0;
		end else if (wr_en && (wr_index < CFG_IDX_W'(SIDE))) begin
			square_q[wr_index] <= wr_data;
		end
	end

	// front: filter, case fold, digraph forming
	pfe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_stream  (in_stream),
		.room       (room),
		.push       (push),
		.push_entry (push_entry)
	);

	// decoupling queue, one entry per byte that causes letters
	pfe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.room       (room),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// back: square lookup and cipher letter output
	pfe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.square     (square_q),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_stream (out_stream)
	);

endmodule
